// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the core RTL file of the clock-to-epoch converter.
// Every macro expects clk and the active-low async reset arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, off while reset is asserted.
`define RTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true at a rising edge of clk outside reset.
`define RTE_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/rte_pkg.sv =====
// Shared types and constants of the clock-to-epoch converter.
// No dependencies; imported by rte_decode and the top level.
package rte_pkg;

	// Clock register bytes: seconds, minutes, hours, day, month, year
	localparam int unsigned NUM_FIELDS = 6;
	localparam int unsigned FLD_SEC    = 0;
	localparam int unsigned FLD_MIN    = 1;
	localparam int unsigned FLD_HOUR   = 2;
	localparam int unsigned FLD_DAY    = 3;
	localparam int unsigned FLD_MON    = 4;
	localparam int unsigned FLD_YEAR   = 5;

	typedef logic [NUM_FIELDS-1:0][7:0] bytes_t;

	// Year windowing: two-digit years below 70 belong to the 2000s
	localparam logic [7:0]  EPOCH_YY      = 8'd70;
	localparam logic [11:0] CENTURY_BASE  = 12'd1900;
	localparam logic [11:0] CENTURY_NEXT  = 12'd2000;
	localparam logic [11:0] CENTURY_AFTER = 12'd2100;

	// Month rotation: January and February move to the end of the prior year
	localparam logic [7:0] LAST_SHIFTED_MON = 8'd2;
	localparam logic [7:0] MON_WRAP_ADD     = 8'd10;
	localparam logic [7:0] MON_SHIFT_SUB    = 8'd2;

	// Gauss day count
	localparam logic [8:0]  MONTH_MUL     = 9'd367;
	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	localparam logic [31:0] DAY_OFFSET    = 32'd719499;
	// Reciprocal of 3 in 0.17 fixed point, exact for dividends below 2^17
	localparam logic [15:0] RECIP3        = 16'd43691;
	localparam int unsigned RECIP3_SHIFT  = 17;

	// Centuries and 400-year cycles of the years that can occur (1969 to 2155)
	localparam logic [4:0] CENT_19 = 5'd19;
	localparam logic [4:0] CENT_20 = 5'd20;
	localparam logic [4:0] CENT_21 = 5'd21;
	localparam logic [2:0] QUAD_4  = 3'd4;
	localparam logic [2:0] QUAD_5  = 3'd5;

	// Time of day
	localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
	localparam logic [16:0] SEC_PER_DAY  = 17'd86400;

endpackage

// ===== hw/rtl/rte_decode.sv =====
// Decodes the clock register bytes from BCD or passes them as binary.
// Depends on rte_pkg for the byte bundle type.
module rte_decode (
	input  logic           bcd_mode,
	input  rte_pkg::bytes_t raw,
	output rte_pkg::bytes_t dec
);
	import rte_pkg::*;

	// High nibble times ten plus low nibble; nibbles above 9 weigh as they stand
	always_comb begin
		for (int i = 0; i < NUM_FIELDS; i++) begin
			if (bcd_mode) begin
				dec[i] = {1'b0, raw[i][7:4], 3'b000} + {3'b000, raw[i][7:4], 1'b0}
					+ {4'b0000, raw[i][3:0]};
			end else begin
				dec[i] = raw[i];
			end
		end
	end

endmodule

// ===== hw/rtl/rtc_calendar_to_epoch_seconds_core.sv =====
// Channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | raw_seconds .. raw_year, 8 bits each
// out     | out | out_valid/out_stall| epoch_seconds, 32 bits
// cfg     | in  | wr_en              | wr_data -> bcd_mode
//
// Six register stages; one item per cycle while out is not stalled.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// are squeezed out and a stall on out only halts the stages that are full.
// Reset empties the pipeline and sets BCD mode.
// Depends on rte_pkg, rte_decode and assert_macros.svh.
`include "assert_macros.svh"

module rtc_calendar_to_epoch_seconds_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  raw_seconds,
	input  logic [7:0]  raw_minutes,
	input  logic [7:0]  raw_hours,
	input  logic [7:0]  raw_day,
	input  logic [7:0]  raw_month,
	input  logic [7:0]  raw_year,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] epoch_seconds
);
	import rte_pkg::*;

	logic bcd_mode_q;

	// valid bits and stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	bytes_t raw_in, dec_d;

	// stage 1: decoded bytes
	bytes_t dec_s1;
	// stage 2: rotated year and month
	logic [11:0] year_s2;
	logic [7:0]  mon_s2, day_s2, hour_s2, min_s2, sec_s2;
	// stage 3: products and leap count
	logic [14:0] mq_s3;
	logic [19:0] ydays_s3;
	logic [9:0]  leap_s3;
	logic [7:0]  day_s3;
	logic [19:0] hms_s3;
	// stage 4: month days and partial day count
	logic [12:0] mdays_s4;
	logic [31:0] base_s4;
	logic [19:0] hms_s4;
	// stage 5: day count
	logic [31:0] days_s5;
	logic [19:0] hms_s5;
	// stage 6: result
	logic [31:0] epoch_s6;

	// combinational stage inputs
	logic        early_mon, next_cent;
	logic [11:0] year_d;
	logic [7:0]  mon_d;
	logic [16:0] mprod_d;
	logic [4:0]  cent_d;
	logic [2:0]  quad_d;
	logic [9:0]  leap_d;
	logic [19:0] hms_d;
	logic [30:0] mrecip_d;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_mode_q <= 1'b1;
		end else if (wr_en) begin
			bcd_mode_q <= wr_data;
		end
	end

	// a stage loads when it is empty or its contents move on
	assign en6 = !v_s6 || !out_stall;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: BCD decode or binary pass-through
	always_comb begin
		raw_in[FLD_SEC]  = raw_seconds;
		raw_in[FLD_MIN]  = raw_minutes;
		raw_in[FLD_HOUR] = raw_hours;
		raw_in[FLD_DAY]  = raw_day;
		raw_in[FLD_MON]  = raw_month;
		raw_in[FLD_YEAR] = raw_year;
	end

	rte_decode u_decode (
		.bcd_mode (bcd_mode_q),
		.raw      (raw_in),
		.dec      (dec_d)
	);

	// stage 2: century window and month rotation
	always_comb begin
		early_mon = dec_s1[FLD_MON] <= LAST_SHIFTED_MON;
		year_d = {4'b0000, dec_s1[FLD_YEAR]}
			+ ((dec_s1[FLD_YEAR] < EPOCH_YY) ? CENTURY_NEXT : CENTURY_BASE)
			- {11'd0, early_mon};
		mon_d = early_mon ? (dec_s1[FLD_MON] + MON_WRAP_ADD)
			: (dec_s1[FLD_MON] - MON_SHIFT_SUB);
	end

	// stage 3: 367*M, 365*Y, leap days and time of day
	always_comb begin
		mprod_d   = 17'(mon_s2) * 17'(MONTH_MUL);
		next_cent = year_s2 >= CENTURY_NEXT;
		// years stay within 1969 to 2155, so Y/100 and Y/400 are range checks
		if (year_s2 >= CENTURY_AFTER) begin
			cent_d = CENT_21;
		end else if (next_cent) begin
			cent_d = CENT_20;
		end else begin
			cent_d = CENT_19;
		end
		quad_d = next_cent ? QUAD_5 : QUAD_4;
		leap_d = year_s2[11:2] - 10'(cent_d) + 10'(quad_d);
		hms_d  = 20'(hour_s2) * 20'(SEC_PER_HOUR) + 20'(min_s2) * 20'(SEC_PER_MIN)
			+ 20'(sec_s2);
	end

	// stage 4: divide (367*M)/4 by 3 through the reciprocal
	assign mrecip_d = 31'(mq_s3) * 31'(RECIP3);

	always_ff @(posedge clk) begin
		if (en1) begin
			dec_s1 <= dec_d;
		end
		if (en2) begin
			year_s2 <= year_d;
			mon_s2  <= mon_d;
			day_s2  <= dec_s1[FLD_DAY];
			hour_s2 <= dec_s1[FLD_HOUR];
			min_s2  <= dec_s1[FLD_MIN];
			sec_s2  <= dec_s1[FLD_SEC];
		end
		if (en3) begin
			mq_s3    <= mprod_d[16:2];
			ydays_s3 <= 20'(year_s2) * 20'(DAYS_PER_YEAR);
			leap_s3  <= leap_d;
			day_s3   <= day_s2;
			hms_s3   <= hms_d;
		end
		if (en4) begin
			mdays_s4 <= mrecip_d[RECIP3_SHIFT +: 13];
			base_s4  <= 32'(ydays_s3) + 32'(leap_s3) + 32'(day_s3) - DAY_OFFSET;
			hms_s4   <= hms_s3;
		end
		if (en5) begin
			days_s5 <= base_s4 + 32'(mdays_s4);
			hms_s5  <= hms_s4;
		end
		// stage 6: scale days to seconds, wrapping modulo 2^32
		if (en6) begin
			epoch_s6 <= days_s5 * 32'(SEC_PER_DAY) + 32'(hms_s5);
		end
	end

	assign out_valid     = v_s6;
	assign epoch_seconds = epoch_s6;

	// input back-pressure only arises from a full pipeline held at the output
	`RTE_ASSERT(a_stall_from_out, in_stall |-> (out_valid && out_stall), "in_stall without held output")
	// an item in the last stage before the output moves on when out is free
	`RTE_ASSERT(a_s5_advance, (v_s5 && !out_stall) |=> out_valid, "stage 5 item lost")
	// an empty output register never holds off the input
	`RTE_ASSERT_NEVER(a_no_idle_stall, in_stall && !v_s6, "stall with empty output stage")

endmodule
